// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes, widths and controller/datapath interface types for the
// text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CELL_IDX_W = 11;

    // control character codes
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

    // attribute after reset
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

    // result action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_NL     = 3'd1,
        OP_CR     = 3'd2,
        OP_SCROLL = 3'd3,
        OP_PUT    = 3'd4,
        OP_BS     = 3'd5
    } op_t;

    // controller to datapath
    typedef struct packed {
        op_t  op;
        logic last;
        logic latch;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_end;
        logic at_zero;
        logic nl_wraps;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes a character; one datapath op per cycle while not stalled.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int TAB_STOP = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  tcw_pkg::status_t                  status,
    input  logic [$clog2(TAB_STOP+1)-1:0]     tab_count,
    output tcw_pkg::cmd_t                     cmd
);

    localparam int CNT_W = $clog2(TAB_STOP+1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PUT    = 4'b0010,
        S_SCROLL = 4'b0100,
        S_BACK   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd.op     = tcw_pkg::OP_NONE;
        cmd.last   = 1'b0;
        cmd.latch  = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (char_code)
                        tcw_pkg::CODE_NL:
                        begin
                            if (status.nl_wraps)
                                state_next = S_SCROLL;
                            else
                                cmd.op = tcw_pkg::OP_NL;
                        end
                        tcw_pkg::CODE_CR:
                            cmd.op = tcw_pkg::OP_CR;
                        tcw_pkg::CODE_BS:
                        begin
                            if (!status.at_zero)
                                state_next = S_BACK;
                        end
                        tcw_pkg::CODE_TAB:
                        begin
                            count_next = tab_count;
                            state_next = S_PUT;
                        end
                        default:
                        begin
                            count_next = CNT_W'(1);
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    // scroll first when the cursor sits past the screen
                    if (status.at_end)
                        cmd.op = tcw_pkg::OP_SCROLL;
                    else
                    begin
                        cmd.op     = tcw_pkg::OP_PUT;
                        cmd.last   = (count_reg == CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                            state_next = S_IDLE;
                    end
                end
            end
            S_SCROLL:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tcw_pkg::OP_SCROLL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BACK:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tcw_pkg::OP_BS;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor row/column/linear registers, attribute register and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcw_pkg::cmd_t                      cmd,
    output tcw_pkg::status_t                   status,
    output logic [$clog2(TAB_STOP+1)-1:0]      tab_count,
    input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
    input  logic                               cfg_valid,
    input  logic [tcw_pkg::COLOR_W-1:0]        text_color,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               action,
    output logic [tcw_pkg::CELL_IDX_W-1:0]     cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    output logic [tcw_pkg::CELL_IDX_W-1:0]     cursor_after,
    output logic                               last
);

    localparam int CELL_W = $clog2(COLUMNS*ROWS+1);
    localparam int ROW_W  = $clog2(ROWS+1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CNT_W  = $clog2(TAB_STOP+1);
    localparam logic [CELL_W-1:0] ROW_STEP       = CELL_W'(COLUMNS);
    localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'((ROWS-1)*COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_END        = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST       = ROW_W'(ROWS-1);
    localparam logic [COL_W-1:0]  COL_LAST       = COL_W'(COLUMNS-1);
    localparam logic [PH_W-1:0]   PH_LAST        = PH_W'(TAB_STOP-1);
    localparam logic [PH_W-1:0]   PH_COL_LAST    = PH_W'((COLUMNS-1) % TAB_STOP);

    // cursor held as row, column, tab phase, row base and linear cell
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [CELL_W-1:0] base_reg, base_next;
    logic [CELL_W-1:0] cursor_reg, cursor_next;
    logic [tcw_pkg::COLOR_W-1:0] color_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;

    logic                        load;
    logic                        res_action;
    logic [CELL_W-1:0]           res_index;
    logic [tcw_pkg::CHAR_W-1:0]  res_char;
    logic [tcw_pkg::COLOR_W-1:0] res_color;
    logic [CELL_W-1:0]           res_after;

    logic                               out_valid_reg, out_valid_next;
    logic                               action_reg;
    logic [tcw_pkg::CELL_IDX_W-1:0]     cell_index_reg;
    logic [tcw_pkg::CHAR_W-1:0]         cell_char_reg;
    logic [tcw_pkg::COLOR_W-1:0]        cell_color_reg;
    logic [tcw_pkg::CELL_IDX_W-1:0]     cursor_after_reg;
    logic                               last_reg;

    assign status.at_end   = (row_reg == ROW_END);
    assign status.at_zero  = (cursor_reg == '0);
    assign status.nl_wraps = (row_reg >= ROW_LAST);
    assign status.out_free = !out_valid_reg || out_ready;
    assign tab_count       = CNT_W'(TAB_STOP) - CNT_W'(phase_reg);

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        phase_next  = phase_reg;
        base_next   = base_reg;
        cursor_next = cursor_reg;
        load        = 1'b0;
        res_action  = tcw_pkg::ACT_WRITE;
        res_index   = '0;
        res_char    = '0;
        res_color   = '0;
        res_after   = cursor_reg;
        case (cmd.op)
            tcw_pkg::OP_NL:
            begin
                row_next    = row_reg + ROW_W'(1);
                col_next    = '0;
                phase_next  = '0;
                base_next   = base_reg + ROW_STEP;
                cursor_next = base_reg + ROW_STEP;
            end
            tcw_pkg::OP_CR:
            begin
                col_next    = '0;
                phase_next  = '0;
                cursor_next = base_reg;
            end
            tcw_pkg::OP_SCROLL:
            begin
                row_next    = ROW_LAST;
                col_next    = '0;
                phase_next  = '0;
                base_next   = LAST_ROW_START;
                cursor_next = LAST_ROW_START;
                load        = 1'b1;
                res_action  = tcw_pkg::ACT_SCROLL;
                res_after   = LAST_ROW_START;
            end
            tcw_pkg::OP_PUT:
            begin
                load        = 1'b1;
                res_index   = cursor_reg;
                res_char    = char_reg;
                res_color   = color_reg;
                cursor_next = cursor_reg + CELL_W'(1);
                res_after   = cursor_reg + CELL_W'(1);
                if (col_reg == COL_LAST)
                begin
                    row_next   = row_reg + ROW_W'(1);
                    col_next   = '0;
                    phase_next = '0;
                    base_next  = base_reg + ROW_STEP;
                end
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + PH_W'(1);
                end
            end
            tcw_pkg::OP_BS:
            begin
                load        = 1'b1;
                res_index   = cursor_reg - CELL_W'(1);
                res_char    = tcw_pkg::CODE_SPACE;
                res_color   = color_reg;
                cursor_next = cursor_reg - CELL_W'(1);
                res_after   = cursor_reg - CELL_W'(1);
                if (col_reg == '0)
                begin
                    row_next   = row_reg - ROW_W'(1);
                    col_next   = COL_LAST;
                    phase_next = PH_COL_LAST;
                    base_next  = base_reg - ROW_STEP;
                end
                else
                begin
                    col_next   = col_reg - COL_W'(1);
                    phase_next = (phase_reg == '0) ? PH_LAST : phase_reg - PH_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            base_reg      <= '0;
            cursor_reg    <= '0;
            color_reg     <= tcw_pkg::COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                color_reg <= text_color;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            char_reg <= (char_code == tcw_pkg::CODE_TAB) ? tcw_pkg::CODE_SPACE : char_code;
        if (load)
        begin
            action_reg       <= res_action;
            cell_index_reg   <= tcw_pkg::CELL_IDX_W'(res_index);
            cell_char_reg    <= res_char;
            cell_color_reg   <= res_color;
            cursor_after_reg <= tcw_pkg::CELL_IDX_W'(res_after);
            last_reg         <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign cell_index   = cell_index_reg;
    assign cell_char    = cell_char_reg;
    assign cell_color   = cell_color_reg;
    assign cursor_after = cursor_after_reg;
    assign last         = last_reg;

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Character-cell console writer: turns character codes into cell writes and
// scroll actions while tracking the cursor on a COLUMNS x ROWS screen.
// ----------------------------------------------------------------------------
// first result: the accepting edge decodes the character into the sequencer state,
//   and a later edge loads the result register once that register is free
// throughput: one result per cycle while out_ready is high, from a single result
//   register; a new character is taken only while the sequencer is idle, that is
//   after the last result of the previous character has been loaded
// reset: cursor at the top left cell, attribute 7, no result pending
// ----------------------------------------------------------------------------
module text_console_char_writer_top #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // character input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
    // attribute register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]        text_color,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               action,
    output logic [tcw_pkg::CELL_IDX_W-1:0]     cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    output logic [tcw_pkg::CELL_IDX_W-1:0]     cursor_after,
    output logic                               last
);

    localparam int CNT_W = $clog2(TAB_STOP+1);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;
    logic [CNT_W-1:0] tab_count;

    // the attribute register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: one datapath operation per cycle while busy and the result register is free
    tcw_ctrl #(
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .status    (status),
        .tab_count (tab_count),
        .cmd       (cmd)
    );

    // cursor tracking, attribute and result register
    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .tab_count    (tab_count),
        .char_code    (char_code),
        .cfg_valid    (cfg_valid),
        .text_color   (text_color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .cell_index   (cell_index),
        .cell_char    (cell_char),
        .cell_color   (cell_color),
        .cursor_after (cursor_after),
        .last         (last)
    );

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the result channel of the console writer.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               action,
    input logic [tcw_pkg::CELL_IDX_W-1:0]     cell_index,
    input logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    input logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    input logic [tcw_pkg::CELL_IDX_W-1:0]     cursor_after,
    input logic                               last
);

    localparam logic [tcw_pkg::CELL_IDX_W-1:0] LAST_ROW_START =
        tcw_pkg::CELL_IDX_W'((ROWS-1)*COLUMNS);

    // a stalled result transaction holds its valid, action, index, cursor_after and last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(cell_index) && $stable(cursor_after) && $stable(last))
    else $error("result changed while stalled");

    // scroll puts the cursor at the start of the last row with an empty cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == tcw_pkg::ACT_SCROLL |->
            cursor_after == LAST_ROW_START && cell_index == '0
            && cell_char == '0 && cell_color == '0)
    else $error("bad scroll result");

    // a write leaves the cursor on the cell or just after it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == tcw_pkg::ACT_WRITE |->
            cursor_after == cell_index
            || cursor_after == tcw_pkg::CELL_IDX_W'(cell_index + 1'b1))
    else $error("cursor not next to written cell");

    // a scroll that is not the final result of its character is not followed by a second scroll
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && action == tcw_pkg::ACT_SCROLL && !last
            |=> !(out_valid && action == tcw_pkg::ACT_SCROLL))
    else $error("two scrolls for one character");

endmodule

bind text_console_char_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .cell_index   (cell_index),
    .cell_char    (cell_char),
    .cell_color   (cell_color),
    .cursor_after (cursor_after),
    .last         (last)
);
